[sv/mda32_pkg.sv]
package mda32_pkg;

  // Reset value of the initial chain register
  localparam logic [31:0] InitValueReset = 32'habba1234;

  // Adler sums restart at these values for every block
  localparam logic [10:0] SumLowReset  = 11'd1;
  localparam logic [13:0] SumHighReset = 14'd0;

  // One input beat as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_byte;
    logic       last;
  } item_t;

  // Result handed from the core to the output register
  typedef struct packed {
    logic        valid;
    logic [31:0] hash_value;
  } result_t;

  // Block checksum: high half carries s2, low half carries s1
  function automatic logic [31:0] block_check(input logic [13:0] s2, input logic [10:0] s1);
    block_check = {2'b00, s2, 5'b00000, s1};
  endfunction

endpackage

[sv/mda32_in_stage.sv]
module mda32_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            take_i,
  input  mda32_pkg::item_t item_i,
  output logic            valid_o,
  output mda32_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  mda32_pkg::item_t item_q;

  // Slot fills on an accepted beat, empties when the core takes it
  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/mda32_core.sv]
module mda32_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              proc_i,
  input  mda32_pkg::item_t  item_i,
  output mda32_pkg::result_t res_o
);

  logic [31:0] init_q;
  logic [31:0] chain_q, chain_d;
  logic [10:0] s1_q, s1_d;
  logic [13:0] s2_q, s2_d;
  logic [2:0]  pos_q, pos_d;

  // Values after the byte step
  logic [10:0] s1_a;
  logic [13:0] s2_a;
  logic [2:0]  pos_a;
  logic [31:0] chain_a;
  // Values after padding a partial final block
  logic [2:0]  pad;
  logic [13:0] s2_p;
  logic [31:0] chain_f;

  always_comb begin
    // Byte step
    s1_a    = s1_q;
    s2_a    = s2_q;
    pos_a   = pos_q;
    chain_a = chain_q;
    if (!item_i.no_byte) begin
      s1_a  = 11'(s1_q + {3'b000, item_i.data_byte});
      s2_a  = 14'(s2_q + {3'b000, s1_a});
      pos_a = 3'(pos_q + 3'd1);
      if (pos_a == 3'd0) begin
        chain_a = chain_q ^ mda32_pkg::block_check(s2_a, s1_a);
        s1_a    = mda32_pkg::SumLowReset;
        s2_a    = mda32_pkg::SumHighReset;
      end
    end

    // Zero padding adds s1 to s2 once per missing byte
    pad     = 3'(3'd0 - pos_a);
    s2_p    = 14'(s2_a + 14'({3'b000, s1_a} * {11'd0, pad}));
    chain_f = chain_a;
    if (pos_a != 3'd0) begin
      chain_f = chain_a ^ mda32_pkg::block_check(s2_p, s1_a);
    end

    // Next state
    chain_d = chain_q;
    s1_d    = s1_q;
    s2_d    = s2_q;
    pos_d   = pos_q;
    if (proc_i) begin
      if (item_i.last) begin
        chain_d = init_q;
        s1_d    = mda32_pkg::SumLowReset;
        s2_d    = mda32_pkg::SumHighReset;
        pos_d   = 3'd0;
      end else begin
        chain_d = chain_a;
        s1_d    = s1_a;
        s2_d    = s2_a;
        pos_d   = pos_a;
      end
    end
    if (cfg_we_i) begin
      chain_d = cfg_data_i;
    end

    res_o.valid      = proc_i && item_i.last;
    res_o.hash_value = chain_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= mda32_pkg::InitValueReset;
      chain_q <= mda32_pkg::InitValueReset;
      s1_q    <= mda32_pkg::SumLowReset;
      s2_q    <= mda32_pkg::SumHighReset;
      pos_q   <= 3'd0;
    end else begin
      if (cfg_we_i) begin
        init_q <= cfg_data_i;
      end
      chain_q <= chain_d;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      pos_q   <= pos_d;
    end
  end

endmodule

[sv/merkle_damgard_adler32_hash.sv]
// Byte-stream hash: 8-byte blocks, each compressed by Adler-style sums (11-bit
// s1, 14-bit s2, no modulus) and XORed into a 32-bit chain that starts at the initial value register.
//
// Input channel: one message byte per beat (data_byte_i), no_byte_i marks a
// beat with no byte, last_i closes the message. Beats with valid high and
// stall low are taken; one beat per cycle is taken as long as the output
// side drains.
// Output channel: one hash_value_o beat per message, registered. The closing
// input beat passes the input register, then the result register; a
// closing beat waits in the input register while the result is stalled.
// Throughput is one input beat per cycle while the output side drains.
// Config channel: cfg_data_i writes the initial value; ready is low while an
// input beat is still held. A write also reloads the running chain.
// Reset loads the initial value 0xabba1234, sets s1 to 1, s2 and the block
// position to 0 and empties both registers. While the receiver stalls, the
// result is held; beats without last keep flowing, and a closing beat waits
// in the input register, which then stalls the input channel.
module merkle_damgard_adler32_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        no_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  mda32_pkg::item_t   in_item;
  mda32_pkg::item_t   s1_item;
  mda32_pkg::result_t res;
  logic               s1_valid;
  logic               out_free;
  logic               proc;
  logic               in_load;
  logic               cfg_we;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        hash_q;

  // Handshake control
  assign out_free    = !out_valid_q || !out_stall_i;
  assign proc        = s1_valid && (!s1_item.last || out_free);
  assign in_stall_o  = s1_valid && !proc;
  assign in_load     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !s1_valid;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign in_item.data_byte = data_byte_i;
  assign in_item.no_byte   = no_byte_i;
  assign in_item.last      = last_i;

  mda32_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_load),
    .take_i  (proc),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  mda32_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .proc_i     (proc),
    .item_i     (s1_item),
    .res_o      (res)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (res.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      hash_q <= res.hash_value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  // Input side stalls only under output backpressure
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // A closing beat taken by the core shows up as a result next cycle
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && s1_item.last) |=> out_valid_o)
    else $error("closing beat produced no result");

  // A beat without last never creates a result
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !s1_item.last) |=> (out_valid_o == $past(out_valid_o && out_stall_i)))
    else $error("result appeared without a closing beat");

  // Config writes only land while no beat is held
  a_cfg_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |-> !proc)
    else $error("config write during item processing");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int StuckLimit   = 2000;
  localparam int HoldOffLen   = 150;
  localparam int DrainCycles  = 8;
  localparam int PhaseItems   = 360;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        no_byte_i = 1'b0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] hash_value_o;

  merkle_damgard_adler32_hash DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .no_byte_i   (no_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hash_value_o(hash_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the hash state
  logic [31:0] seed_value = mda32_pkg::InitValueReset;
  logic [31:0] chain_shadow = mda32_pkg::InitValueReset;
  logic [10:0] adler_s1 = mda32_pkg::SumLowReset;
  logic [13:0] adler_s2 = mda32_pkg::SumHighReset;
  logic [2:0]  byte_slot = '0;

  logic [31:0] hash_q[$];

  int errors = 0;
  int stuck_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int msgs_done = 0;
  int bytes_taken = 0;
  int hashes_checked = 0;
  int seeds_written = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch %s: got %08h want %08h", $time, what, got, want);
    errors++;
  endtask

  function automatic void restart_block();
    adler_s1 = mda32_pkg::SumLowReset;
    adler_s2 = mda32_pkg::SumHighReset;
    byte_slot = '0;
  endfunction

  function automatic void fold_block();
    chain_shadow ^= {2'b00, adler_s2, 5'b00000, adler_s1};
    restart_block();
  endfunction

  // Advance the shadow hash by one accepted beat
  function automatic void hash_beat(input logic [7:0] b, input logic nb, input logic lst);
    logic [31:0] pad_sum;
    if (!nb) begin
      adler_s1 = adler_s1 + 11'(b);
      adler_s2 = adler_s2 + 14'(adler_s1);
      byte_slot = byte_slot + 3'd1;
      if (byte_slot == 3'd0) fold_block();
    end
    if (lst) begin
      if (byte_slot != 3'd0) begin
        // zero padding: s1 unchanged, s2 gains s1 per pad byte
        pad_sum = (32'd8 - 32'(byte_slot)) * 32'(adler_s1);
        adler_s2 = adler_s2 + pad_sum[13:0];
        fold_block();
      end
      hash_q.insert(hash_q.size(), chain_shadow);
      chain_shadow = seed_value;
      restart_block();
    end
  endfunction

  // Monitor: config beats, input beats, result beats, watchdog count
  always @(posedge clk_i) begin
    logic any_beat;
    any_beat = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        seed_value = cfg_data_i;
        chain_shadow = cfg_data_i;
        seeds_written++;
        any_beat = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        hash_beat(data_byte_i, no_byte_i, last_i);
        if (!no_byte_i) bytes_taken++;
        if (last_i) msgs_done++;
        any_beat = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        any_beat = 1'b1;
        if (hash_q.size() == 0) begin
          report_mismatch("unexpected hash", hash_value_o, 32'h0);
        end else begin
          if (hash_value_o !== hash_q[0])
            report_mismatch("hash_value", hash_value_o, hash_q[0]);
          void'(hash_q.pop_front());
          hashes_checked++;
        end
      end
      stuck_cycles = any_beat ? 0 : stuck_cycles + 1;
    end
  end

  // Receiver: random stall, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $display("%0t: no beat for %0d cycles, %0d hashes pending", $time, StuckLimit,
             hash_q.size());
    $display("FAIL");
    $finish;
  end

  // Offer one beat and wait until it is taken; valid stays high afterwards
  task automatic send_item(input logic [7:0] b, input logic nb, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    no_byte_i   <= nb;
    last_i      <= lst;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every hash has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // One well-formed message with random length, content and closing style
  task automatic send_random_message(inout int items);
    int  len;
    bit  marker;
    case ($urandom_range(9))
      0:       len = 0;
      1, 2:    len = 8 * $urandom_range(1, 3);
      9:       len = $urandom_range(25, 64);
      default: len = $urandom_range(1, 15);
    endcase
    marker = (len == 0) || ($urandom_range(3) == 0);
    for (int k = 0; k < len; k++) begin
      // stray beat with neither byte nor end marker
      if ($urandom_range(15) == 0) send_item(8'($urandom), 1'b1, 1'b0);
      send_item(pick_byte(), 1'b0, !marker && (k == len - 1));
      items++;
    end
    if (marker) begin
      send_item(8'($urandom), 1'b1, 1'b1);
      items++;
    end
  endtask

  // Extremes, whole and padded blocks, empty message, stray beats
  task automatic test_directed();
    send_item(8'h00, 1'b1, 1'b1);                 // empty message at reset value
    send_item(8'hff, 1'b0, 1'b1);                 // one byte, seven pad bytes
    for (int k = 0; k < 8; k++) send_item(8'hff, 1'b0, k == 7);  // whole block
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h5a, 1'b1, 1'b0);                 // ignored beat mid-message
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b1);                 // separate end marker
    send_item(8'hff, 1'b1, 1'b1);                 // empty message after others
    wait_drained();
  endtask

  // Seed extremes, including a write while a message is half done
  task automatic test_seed_writes();
    write_seed(32'h0000_0000);
    send_item(8'h80, 1'b1, 1'b1);
    for (int k = 0; k < 11; k++) send_item(pick_byte(), 1'b0, 1'b0);
    wait_drained();
    write_seed(32'hffff_ffff);                    // sums and slot survive the write
    send_item(8'h01, 1'b0, 1'b0);
    send_item(8'h7f, 1'b0, 1'b1);
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps going, then sender waits it out
  task automatic test_hold_off();
    int items;
    items = 0;
    hold_req = HoldOffLen;
    while (items < 60) send_random_message(items);
    wait_drained();
  endtask

  task automatic test_random_phase(input int snd_pct, input int rcv_pct,
                                   input logic [31:0] seed);
    int items;
    items = 0;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    write_seed(seed);
    while (items < PhaseItems) send_random_message(items);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_seed_writes();
    test_random_phase(10, 71, 32'($urandom));
    test_hold_off();
    test_random_phase(71, 10, 32'hffff_ffff);
    test_random_phase(0, 0, 32'h0000_0000);
    write_seed(mda32_pkg::InitValueReset);
    send_item(8'h00, 1'b1, 1'b1);
    wait_drained();

    if (hash_q.size() != 0)
      report_mismatch("hash never produced", 32'h0, hash_q[0]);
    $display("Hashed %0d messages (%0d bytes) under %0d seed writes, %0d results checked.",
             msgs_done, bytes_taken, seeds_written, hashes_checked);
    $display("Idle mixes 10/71, 71/10 and none, plus a %0d-cycle output hold-off.",
             HoldOffLen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
